[rtl/core/sfcp_pkg.sv]
// Shared types, constants and status codes of the sync frame command parser.
package sfcp_pkg;

  // Default upper bound on the bytes of one frame, sync bytes included.
  localparam int unsigned MAX_FRAME_BYTES_DEF = 32;

  // Width used for frame length arithmetic: covers a length byte plus overhead.
  localparam int unsigned LEN_CMP_W = 9;

  // Frame layout constants.
  localparam int unsigned SYNC_OVERHEAD   = 2;  // sync bytes not counted by the length
  localparam int unsigned MIN_FRAME_LEN   = 3;  // length, checksum and type bytes
  localparam int unsigned LED_FRAME_LEN   = 4;  // set-LEDs frame carries one payload byte
  localparam int unsigned TYPE_POS        = 4;  // byte position of the type byte
  localparam int unsigned FIRST_PAYLD_POS = 5;  // byte position of the first payload byte

  // APB register map.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_LED_TYPE    = 2'd2
  } reg_index_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_LED_OK     = 2'd0,
    STATUS_CSUM_ERR   = 2'd1,
    STATUS_UNSUPPORTED = 2'd2,
    STATUS_BAD_LENGTH = 2'd3
  } frame_status_t;

  // Configuration handed from the register block to the parser.
  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] led_command_type;
  } cfg_t;

  // One parser result.
  typedef struct packed {
    logic          valid;
    frame_status_t status;
    logic [7:0]    led_state;
  } result_t;

endpackage

[rtl/core/sfcp_apb_regs.sv]
// APB configuration registers of the sync frame command parser.
module sfcp_apb_regs
  import sfcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; an address beyond the map is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SYNC_FIRST:  cfg.sync_first       <= pwdata[7:0];
        REG_SYNC_SECOND: cfg.sync_second      <= pwdata[7:0];
        REG_LED_TYPE:    cfg.led_command_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_sel)
      REG_SYNC_FIRST:  prdata = {24'd0, cfg.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg.sync_second};
      REG_LED_TYPE:    prdata = {24'd0, cfg.led_command_type};
      default:         prdata = '0;
    endcase
  end

endmodule

[rtl/core/sfcp_frame_parser.sv]
// Frame state machine, running checksum and result decision for one byte.
module sfcp_frame_parser
  import sfcp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output result_t    result
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  typedef enum logic [4:0] {
    ST_HUNT  = 5'b00001,
    ST_SYNC2 = 5'b00010,
    ST_LEN   = 5'b00100,
    ST_CSUM  = 5'b01000,
    ST_BODY  = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       frame_length, frame_length_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       received_checksum, received_checksum_next;
  logic [7:0]       frame_type, frame_type_next;
  logic [7:0]       first_payload, first_payload_next;

  logic [LEN_CMP_W-1:0] total;
  logic [LEN_CMP_W-1:0] count_inc;
  logic [7:0]           sum_now;
  logic [7:0]           type_now;
  logic [7:0]           led_now;
  logic                 bad_len;
  logic                 clear;

  // Frame arithmetic on the current byte.
  assign total     = LEN_CMP_W'(frame_length) + LEN_CMP_W'(SYNC_OVERHEAD);
  assign count_inc = LEN_CMP_W'(byte_count) + LEN_CMP_W'(1);
  assign sum_now   = running_sum + rx_byte;
  assign type_now  = (byte_count == CNT_W'(TYPE_POS)) ? rx_byte : frame_type;
  assign led_now   = (byte_count == CNT_W'(FIRST_PAYLD_POS)) ? rx_byte : first_payload;
  assign bad_len   = (rx_byte < 8'(MIN_FRAME_LEN)) ||
                     ((LEN_CMP_W'(rx_byte) + LEN_CMP_W'(SYNC_OVERHEAD)) >
                      LEN_CMP_W'(MAX_FRAME_BYTES));

  // Next state and result for one accepted byte.
  always_comb begin
    state_next             = state;
    byte_count_next        = byte_count;
    frame_length_next      = frame_length;
    running_sum_next       = running_sum;
    received_checksum_next = received_checksum;
    frame_type_next        = frame_type;
    first_payload_next     = first_payload;
    clear                  = 1'b0;
    result                 = '{valid: 1'b0, status: STATUS_LED_OK, led_state: 8'd0};
    case (state)
      ST_HUNT: begin
        if (rx_byte == cfg.sync_first) begin
          state_next      = ST_SYNC2;
          byte_count_next = CNT_W'(1);
        end
      end
      ST_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          state_next      = ST_LEN;
          byte_count_next = CNT_W'(2);
        end else begin
          clear = 1'b1;
        end
      end
      ST_LEN: begin
        if (bad_len) begin
          result.valid  = 1'b1;
          result.status = STATUS_BAD_LENGTH;
          clear         = 1'b1;
        end else begin
          state_next        = ST_CSUM;
          frame_length_next = rx_byte;
          running_sum_next  = 8'd0;
          byte_count_next   = CNT_W'(3);
        end
      end
      ST_CSUM: begin
        state_next             = ST_BODY;
        received_checksum_next = rx_byte;
        byte_count_next        = CNT_W'(TYPE_POS);
      end
      ST_BODY: begin
        if (LEN_CMP_W'(byte_count) >= total) begin
          // Count overran the frame: resynchronize.
          clear = 1'b1;
        end else if (count_inc == total) begin
          // Last byte of the frame: decide the outcome.
          result.valid = 1'b1;
          clear        = 1'b1;
          if (sum_now != received_checksum) begin
            result.status = STATUS_CSUM_ERR;
          end else if ((type_now != cfg.led_command_type) ||
                       (frame_length != 8'(LED_FRAME_LEN))) begin
            result.status = STATUS_UNSUPPORTED;
          end else begin
            result.status    = STATUS_LED_OK;
            result.led_state = led_now;
          end
        end else begin
          running_sum_next   = sum_now;
          frame_type_next    = type_now;
          first_payload_next = led_now;
          byte_count_next    = CNT_W'(count_inc);
        end
      end
      default: begin
        clear = 1'b1;
      end
    endcase
    if (clear) begin
      state_next             = ST_HUNT;
      byte_count_next        = '0;
      frame_length_next      = '0;
      running_sum_next       = '0;
      received_checksum_next = '0;
      frame_type_next        = '0;
      first_payload_next     = '0;
    end
    if (!step) begin
      result.valid = 1'b0;
    end
  end

  // Frame state registers, updated only for an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_HUNT;
      byte_count        <= '0;
      frame_length      <= '0;
      running_sum       <= '0;
      received_checksum <= '0;
      frame_type        <= '0;
      first_payload     <= '0;
    end else if (step) begin
      state             <= state_next;
      byte_count        <= byte_count_next;
      frame_length      <= frame_length_next;
      running_sum       <= running_sum_next;
      received_checksum <= received_checksum_next;
      frame_type        <= frame_type_next;
      first_payload     <= first_payload_next;
    end
  end

endmodule

[rtl/core/sync_frame_command_parser.sv]
// Top level of the sync frame command parser: stream ports, staging registers, APB port.
//
// Received serial bytes enter on the s_ stream, one byte per request. The block hunts
// for the two configured sync bytes, then takes a length byte, a checksum byte, a type
// byte and the payload, and issues at most one result per frame on the m_ stream:
// a status code and the LED byte of an accepted set-LEDs command.
// Registers sync_first, sync_second and led_command_type sit at APB byte addresses
// 0, 4 and 8; the user must write them while the stream is idle (the block does not
// enforce this). A byte is captured in an input register and processed by the frame
// parser once the result register can advance; the result register captures the outcome.
// Throughput is one byte per cycle while the receiver does not stall: the frame state
// update is a single pass of compare and 8-bit add logic between the two registers.
// When the receiver stalls, the result register holds its request and the input
// register holds one more byte; s_tready drops only when both are occupied.
// Synchronous reset clears the registers, the frame state and both staging stages.
module sync_frame_command_parser
  import sfcp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [1:0] frame_status, [9:2] led_state
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  result_t    result;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;
  logic [1:0] out_status;
  logic [7:0] out_led;

  sfcp_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The pipeline moves whenever the result register is free or being emptied.
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  sfcp_frame_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .rx_byte (in_byte),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_status <= result.status;
      out_led    <= result.led_state;
    end
  end

  assign m_tdata = {6'd0, out_led, out_status};

endmodule

[rtl/core/sfcp_checker.sv]
// Port-level assertions of the sync frame command parser and their bind.
module sfcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Any rejection carries a zero LED byte.
  a_led_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != 2'd0) |-> (m_tdata[9:2] == 8'd0))
    else $error("rejected frame with nonzero LED byte");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:10] == 6'd0))
    else $error("result padding not zero");

  // An empty result stage always leaves room for a new byte.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result stage");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sync_frame_command_parser sfcp_checker u_sfcp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/sfcp_frame_checker.sv]
// Frame checker for the sync frame command parser: predicts reports and compares them.
module sfcp_frame_checker
  import sfcp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [15:0]           m_tdata,   // [1:0] frame_status, [9:2] led_state
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    pending_reports,
  output int                    mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    frame_status_t status;
    logic [7:0]    led_state;
  } frame_report_t;

  // Register copies, written from the observed APB traffic.
  logic [7:0] cfg_sync_first;
  logic [7:0] cfg_sync_second;
  logic [7:0] cfg_led_type;

  // Frame tracking state of the predictor.
  int         frm_count;
  logic [7:0] frm_len;
  logic [7:0] sum_acc;
  logic [7:0] csum_rx;
  logic [7:0] frm_type;
  logic [7:0] led_byte;

  frame_report_t expected_reports[$];

  initial begin
    pending_reports = 0;
    mismatch_count  = 0;
  end

  function automatic void restart_hunt();
    frm_count = 0;
    frm_len   = 8'h00;
    sum_acc   = 8'h00;
    csum_rx   = 8'h00;
    frm_type  = 8'h00;
    led_byte  = 8'h00;
  endfunction

  // Closes the current frame with a report and goes back to hunting.
  function automatic bit close_frame(input frame_status_t st, input logic [7:0] led,
                                     output frame_report_t rep);
    rep.status    = st;
    rep.led_state = led;
    restart_hunt();
    return 1'b1;
  endfunction

  // Advances the frame state by one received byte; returns 1 when a report is due.
  function automatic bit parse_rx_byte(input logic [7:0] d, output frame_report_t rep);
    int total;
    rep = '{STATUS_LED_OK, 8'h00};
    if (frm_count == 0) begin
      if (d == cfg_sync_first) frm_count = 1;
      return 1'b0;
    end
    if (frm_count == 1) begin
      if (d == cfg_sync_second) frm_count = 2;
      else restart_hunt();
      return 1'b0;
    end
    if (frm_count == 2) begin
      if (int'(d) < MIN_FRAME_LEN || int'(d) + SYNC_OVERHEAD > MAX_FRAME_BYTES)
        return close_frame(STATUS_BAD_LENGTH, 8'h00, rep);
      frm_len   = d;
      sum_acc   = 8'h00;
      frm_count = 3;
      return 1'b0;
    end
    if (frm_count == 3) begin
      csum_rx   = d;
      frm_count = 4;
      return 1'b0;
    end
    total = int'(frm_len) + SYNC_OVERHEAD;
    // Out-of-range count should never happen; fall back to hunting.
    if (frm_count >= total) begin
      restart_hunt();
      return 1'b0;
    end
    sum_acc = sum_acc + d;
    if (frm_count == TYPE_POS) frm_type = d;
    else if (frm_count == FIRST_PAYLD_POS) led_byte = d;
    frm_count++;
    if (frm_count != total) return 1'b0;
    if (sum_acc != csum_rx) return close_frame(STATUS_CSUM_ERR, 8'h00, rep);
    if (frm_type != cfg_led_type || frm_len != LED_FRAME_LEN)
      return close_frame(STATUS_UNSUPPORTED, 8'h00, rep);
    return close_frame(STATUS_LED_OK, led_byte, rep);
  endfunction

  // Sample both streams and the APB port at every rising edge.
  always @(posedge clk) begin
    frame_report_t rep;
    frame_report_t want;
    if (rst) begin
      cfg_sync_first  = 8'h00;
      cfg_sync_second = 8'h00;
      cfg_led_type    = 8'h00;
      restart_hunt();
      expected_reports.delete();
    end else begin
      // Compare an accepted result with the oldest expected report.
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result: m_tdata 0x%04h with no report expected", m_tdata);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          if (m_tdata[1:0] !== want.status) begin
            $error("frame_status mismatch: expected %0d, actual %0d",
                   want.status, m_tdata[1:0]);
            mismatch_count++;
          end
          if (m_tdata[9:2] !== want.led_state) begin
            $error("led_state mismatch: expected 0x%02h, actual 0x%02h",
                   want.led_state, m_tdata[9:2]);
            mismatch_count++;
          end
          if (m_tdata[15:10] !== 6'd0) begin
            $error("tdata padding mismatch: expected 0x00, actual 0x%02h", m_tdata[15:10]);
            mismatch_count++;
          end
        end
      end
      // Predict the effect of each accepted request.
      if (s_tvalid && s_tready) begin
        if (parse_rx_byte(s_tdata, rep)) expected_reports.push_back(rep);
      end
      // Track register writes; unmapped addresses are ignored.
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[APB_ADDR_W-1:2]))
          REG_SYNC_FIRST:  cfg_sync_first  = pwdata[7:0];
          REG_SYNC_SECOND: cfg_sync_second = pwdata[7:0];
          REG_LED_TYPE:    cfg_led_type    = pwdata[7:0];
          default: ;
        endcase
      end
    end
    pending_reports <= expected_reports.size();
  end

endmodule

[tb/tb_sync_frame_command_parser.sv]
// Testbench top for the sync frame command parser: clock, reset, stimulus and verdict.
module tb_sync_frame_command_parser;
  import sfcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                    HOLD_OFF_CYCLES = 400;
  localparam int                    ITEMS_PER_PHASE = 145;
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR   = 4'hC;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = 8'h00;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int pending_reports;
  int mismatch_count;

  // Stimulus-side view of the registers, used to build frames.
  logic [7:0] tx_sync_first  = 8'h00;
  logic [7:0] tx_sync_second = 8'h00;
  logic [7:0] tx_led_type    = 8'h00;

  int bytes_sent      = 0;
  int burst_left      = 1;
  bit hold_off_req    = 1'b0;

  always #5 clk = ~clk;

  sync_frame_command_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  sfcp_frame_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .pending_reports (pending_reports),
    .mismatch_count  (mismatch_count)
  );

  // Offers one byte and returns at the edge where the request is taken, or after the
  // idle gap that follows it when a burst ends.
  task automatic send_byte(input logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
  endtask

  // Sends one frame with the current sync bytes; length, checksum and type vary.
  task automatic send_frame();
    int         r;
    int         len;
    logic [7:0] ftype;
    logic [7:0] csum;
    logic [7:0] payload [0:29];
    r = $urandom_range(0, 99);
    if (r < 40)      len = LED_FRAME_LEN;
    else if (r < 70) len = $urandom_range(MIN_FRAME_LEN, 8);
    else if (r < 85) len = $urandom_range(9, 30);
    else if (r < 93) len = $urandom_range(0, 2);
    else             len = $urandom_range(31, 255);
    send_byte(tx_sync_first);
    send_byte(tx_sync_second);
    send_byte(8'(len));
    // Bad lengths end the frame right at the length byte.
    if (len >= MIN_FRAME_LEN && len <= 30) begin
      ftype = ($urandom_range(0, 99) < 65) ? tx_led_type : 8'($urandom_range(0, 255));
      csum  = ftype;
      for (int i = 0; i < len - MIN_FRAME_LEN; i++) begin
        payload[i] = 8'($urandom_range(0, 255));
        csum       = csum + payload[i];
      end
      if ($urandom_range(0, 99) >= 80) csum = 8'($urandom_range(0, 255));
      send_byte(csum);
      send_byte(ftype);
      for (int i = 0; i < len - MIN_FRAME_LEN; i++) send_byte(payload[i]);
    end
  endtask

  // Stops offering, waits for all reports, then lets the pipeline drain.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One APB write, after which the bus is left idle.
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [7:0] led_type);
    apb_write({REG_SYNC_FIRST, 2'b00}, s1);
    apb_write({REG_SYNC_SECOND, 2'b00}, s2);
    apb_write({REG_LED_TYPE, 2'b00}, led_type);
    tx_sync_first  = s1;
    tx_sync_second = s2;
    tx_led_type    = led_type;
  endtask

  // Random mix: mostly frames, some noise and some broken sync pairs.
  task automatic run_random(input int count);
    int r;
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_frame();
      end else if (r < 88) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(tx_sync_first);
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver: ready pattern changes mode at random intervals; a long
  // hold-off is taken whenever the stimulus asks for one.
  initial begin : rx_stall
    int         mode;
    int         left;
    int         tick;
    logic [7:0] pattern;
    mode    = 0;
    left    = 0;
    tick    = 0;
    pattern = 8'b1011_0010;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 80);
        end
        left--;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= pattern[tick % 8];
        endcase
      end
    end
  end

  // Main stimulus and verdict.
  initial begin : stimulus
    logic [7:0] dir_seq [0:25];
    dir_seq = '{
      8'h00,                                 // dropped while hunting
      8'hA5, 8'hA5,                          // bad second sync equal to the first
      8'hA5, 8'h5A, 8'h04, 8'h10, 8'h11, 8'hFF,  // accepted LED command
      8'hA5, 8'h5A, 8'h02,                   // length below the minimum
      8'hA5, 8'h5A, 8'h1F,                   // length over the frame limit
      8'hA5, 8'h5A, 8'h03, 8'h11, 8'h11,     // frame without payload
      8'hA5, 8'h5A, 8'h04, 8'h00, 8'h11, 8'h3C   // checksum mismatch
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    set_config(8'hA5, 8'h5A, 8'h11);
    for (int i = 0; i < 26; i++) send_byte(dir_seq[i]);

    // Long receiver hold-off while frames keep coming, so the input stalls.
    hold_off_req = 1'b1;
    for (int i = 0; i < 25; i++) send_frame();
    run_random(ITEMS_PER_PHASE);

    wait_idle();
    set_config(8'h00, 8'h00, 8'h00);
    run_random(ITEMS_PER_PHASE);

    wait_idle();
    set_config(8'hFF, 8'hFF, 8'hFF);
    apb_write(UNMAPPED_ADDR, 8'h5C);
    run_random(ITEMS_PER_PHASE);

    wait_idle();
    set_config(8'h00, 8'hFF, 8'h80);
    run_random(ITEMS_PER_PHASE);

    wait_idle();
    set_config(8'hFF, 8'h00, 8'h01);
    run_random(ITEMS_PER_PHASE);

    wait_idle();
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    run_random(ITEMS_PER_PHASE - 60);

    wait_idle();
    if (mismatch_count == 0 && pending_reports == 0) begin
      $display("tb_sync_frame_command_parser: PASS");
    end else begin
      $display("tb_sync_frame_command_parser: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("tb_sync_frame_command_parser: FAIL");
    $finish;
  end

endmodule

[sync_frame_command_parser.f]
rtl/core/sfcp_pkg.sv
rtl/core/sfcp_apb_regs.sv
rtl/core/sfcp_frame_parser.sv
rtl/core/sync_frame_command_parser.sv
rtl/core/sfcp_checker.sv
tb/sfcp_frame_checker.sv
tb/tb_sync_frame_command_parser.sv
